// File: rtl/core/tbsr_pkg.sv
// shared types and constants for the tcp byte stream reassembler
// used by tbsr_ctrl, tbsr_dp and the top level; no dependencies

package tbsr_pkg;

  localparam int unsigned CAPACITY   = 4096;
  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SPACE_W    = 17;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned RAM_W      = BYTE_W + 1;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_DATA = 2'd0,
    OP_MARK = 2'd1,
    OP_PULL = 2'd2
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted input transfer
    logic clr;     // clearing pass write
    logic commit;  // apply update, write ring, load result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass at last ring entry
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

// File: rtl/core/tbsr_ram.sv
// generic simple dual port ram with registered read
// no dependencies

module tbsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tbsr_ctrl.sv
// controller state machine: clearing pass, accept, read, update
// depends on tbsr_pkg

module tbsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tbsr_pkg::sts_t sts_i,
  output tbsr_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_UPD
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   accept;

  assign accept = in_valid_i && ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RD;
            ready_q <= 1'b0;
          end
        end
        S_RD: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          // hold until the result register has room
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_CLR;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o    = ready_q;
  assign cmd_o.load    = accept;
  assign cmd_o.clr     = (state_q == S_CLR);
  assign cmd_o.commit  = (state_q == S_UPD) && sts_i.out_free;

endmodule

// File: rtl/core/tbsr_dp.sv
// datapath: input registers, window check, ring ram, stream state, result register
// depends on tbsr_pkg and tbsr_ram

module tbsr_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbsr_pkg::cmd_t                      cmd_i,
  output tbsr_pkg::sts_t                      sts_o,
  input  logic [tbsr_pkg::OP_W-1:0]           in_op_i,
  input  logic [tbsr_pkg::IDX_W-1:0]          in_idx_i,
  input  logic [tbsr_pkg::BYTE_W-1:0]         in_byte_i,
  input  logic                                in_last_i,
  input  logic                                in_eof_i,
  input  logic [tbsr_pkg::SPACE_W-1:0]        in_space_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_bvalid_o,
  output logic [tbsr_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                                out_fin_o,
  output logic [tbsr_pkg::CNT_W-1:0]          out_pending_o
);

  localparam int unsigned SW = tbsr_pkg::SLOT_W;
  localparam int unsigned IW = tbsr_pkg::IDX_W;

  // captured item
  logic [tbsr_pkg::OP_W-1:0]    op_q;
  logic [IW-1:0]                idx_q;
  logic [tbsr_pkg::BYTE_W-1:0]  byte_q;
  logic                         last_q;
  logic                         eof_q;
  logic [tbsr_pkg::SPACE_W-1:0] space_q;

  // window check stage
  logic                         in_win_q;
  logic                         end_ok_q;
  logic                         spc_nz_q;

  // stream state
  logic [IW-1:0]                lower_q, lower_d;
  logic [tbsr_pkg::CNT_W-1:0]   held_q, held_d;
  logic                         end_q, end_d;
  logic [SW-1:0]                clr_cnt_q;

  // result register
  logic                         ovalid_q;
  logic                         obv_q, obv_d;
  logic [tbsr_pkg::BYTE_W-1:0]  obyte_q, obyte_d;
  logic                         ofin_q;
  logic [tbsr_pkg::CNT_W-1:0]   opend_q;

  logic [tbsr_pkg::SPACE_W-1:0] win;
  logic [IW:0]                  upper;
  logic                         ram_we, upd_we;
  logic [SW-1:0]                ram_waddr, slot;
  logic [tbsr_pkg::RAM_W-1:0]   ram_wdata, upd_wdata, ram_rdata;
  logic                         rd_present;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      idx_q   <= in_idx_i;
      byte_q  <= in_byte_i;
      last_q  <= in_last_i;
      eof_q   <= in_eof_i;
      space_q <= in_space_i;
    end
  end

  // window is min(space, capacity); upper bound kept one bit wider, no wrap
  assign win = (space_q < tbsr_pkg::SPACE_W'(tbsr_pkg::CAPACITY))
               ? space_q : tbsr_pkg::SPACE_W'(tbsr_pkg::CAPACITY);
  assign upper = {1'b0, lower_q} + (IW+1)'(win);

  always_ff @(posedge clk_i) begin
    in_win_q <= (idx_q >= lower_q) && ({1'b0, idx_q} < upper);
    end_ok_q <= last_q && eof_q && ({1'b0, idx_q} < upper);
    spc_nz_q <= (space_q != '0);
  end

  // capacity is a power of two, so the ring slot is the low index bits
  assign slot = (op_q == tbsr_pkg::OP_PULL) ? lower_q[SW-1:0] : idx_q[SW-1:0];
  assign rd_present = ram_rdata[tbsr_pkg::BYTE_W];

  always_comb begin
    lower_d   = lower_q;
    held_d    = held_q;
    end_d     = end_q;
    obv_d     = 1'b0;
    obyte_d   = '0;
    upd_we    = 1'b0;
    upd_wdata = {1'b1, byte_q};
    case (op_q)
      tbsr_pkg::OP_DATA: begin
        if (in_win_q && !rd_present) begin
          upd_we = 1'b1;
          held_d = held_q + 1'b1;
        end
        if (end_ok_q) begin
          end_d = 1'b1;
        end
      end
      tbsr_pkg::OP_MARK: begin
        if (eof_q) begin
          end_d = 1'b1;
        end
      end
      tbsr_pkg::OP_PULL: begin
        if (rd_present && spc_nz_q) begin
          upd_we    = 1'b1;
          upd_wdata = {1'b0, ram_rdata[tbsr_pkg::BYTE_W-1:0]};
          obv_d     = 1'b1;
          obyte_d   = ram_rdata[tbsr_pkg::BYTE_W-1:0];
          held_d    = held_q - 1'b1;
          lower_d   = lower_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we    = cmd_i.clr || (cmd_i.commit && upd_we);
  assign ram_waddr = cmd_i.clr ? clr_cnt_q : slot;
  assign ram_wdata = cmd_i.clr ? '0 : upd_wdata;

  tbsr_ram #(
    .WIDTH (tbsr_pkg::RAM_W),
    .DEPTH (tbsr_pkg::CAPACITY)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= '0;
      held_q    <= '0;
      end_q     <= 1'b0;
      clr_cnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        lower_q  <= lower_d;
        held_q   <= held_d;
        end_q    <= end_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      obv_q   <= obv_d;
      obyte_q <= obyte_d;
      ofin_q  <= end_d && (held_d == '0);
      opend_q <= held_d;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == SW'(tbsr_pkg::CAPACITY - 1));
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o   = ovalid_q;
  assign out_bvalid_o  = obv_q;
  assign out_byte_o    = obyte_q;
  assign out_fin_o     = ofin_q;
  assign out_pending_o = opend_q;

endmodule

// File: rtl/core/tcp_byte_stream_reassembler.sv
// flow: an accepted input is registered, then the window check and ring read are registered,
// then the update commits into the output register once it has room; one item in flight
// reset: after rst_ni releases, a clearing pass zeroes the ring present marks;
// s_axis_tready stays low until it ends
// depends on tbsr_pkg, tbsr_ctrl, tbsr_dp, tbsr_ram

module tcp_byte_stream_reassembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // stream_index[31:0], data_byte[39:32],
                                      // end_of_input[40], space_free[57:41], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  input  logic        s_axis_tlast,   // segment_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_byte[7:0], stream_finished[8],
                                      // pending_count[25:9], zero pad
  output logic        m_axis_tuser    // byte_valid
);

  tbsr_pkg::cmd_t cmd;
  tbsr_pkg::sts_t sts;

  logic                               bvalid;
  logic [tbsr_pkg::BYTE_W-1:0]        obyte;
  logic                               fin;
  logic [tbsr_pkg::CNT_W-1:0]         pending;

  tbsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbsr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tuser),
    .in_idx_i      (s_axis_tdata[31:0]),
    .in_byte_i     (s_axis_tdata[39:32]),
    .in_last_i     (s_axis_tlast),
    .in_eof_i      (s_axis_tdata[40]),
    .in_space_i    (s_axis_tdata[57:41]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_bvalid_o  (bvalid),
    .out_byte_o    (obyte),
    .out_fin_o     (fin),
    .out_pending_o (pending)
  );

  assign m_axis_tuser = bvalid;
  assign m_axis_tdata = {6'b0, pending, fin, obyte};

endmodule

// File: rtl/core/tbsr_checker.sv
// port level checks for tcp_byte_stream_reassembler, attached by bind
// depends only on the top level ports

module tbsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // one item in flight: no transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted back to back");

  // byte field is zero when no byte is delivered
  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("out_byte nonzero without byte_valid");

  // finished implies nothing pending
  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[25:9] == 17'd0))
    else $error("stream_finished with pending bytes");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind tcp_byte_stream_reassembler tbsr_checker u_tbsr_checker (.*);

// File: tb/sv/tb.sv
// self-checking testbench for tcp_byte_stream_reassembler: directed window cases, random
// segment traffic with idling and back pressure, then end mark cases, checked per transfer
// depends on tbsr_pkg and the reassembler rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [16:0] SPACE_MAX    = 17'd65536;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        finished;
    logic [16:0] pending;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // stream_index, data_byte, end_of_input, space_free, pad
  logic [1:0]  s_axis_tuser;   // operation
  logic        s_axis_tlast;   // segment_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_byte, stream_finished, pending_count, pad
  logic        m_axis_tuser;   // byte_valid

  // shadow of the reassembly window
  logic [7:0]  ring_byte [tbsr_pkg::CAPACITY];
  bit          ring_held [tbsr_pkg::CAPACITY];
  logic [31:0] next_idx;
  logic [16:0] held_cnt;
  bit          end_flag;

  outcome_t    outcome_q [$];
  outcome_t    want;

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned stall_left;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned bytes_delivered;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  tcp_byte_stream_reassembler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic longint unsigned window_of(input logic [16:0] space);
    return (space < tbsr_pkg::CAPACITY) ? longint'(space) : longint'(tbsr_pkg::CAPACITY);
  endfunction

  // true when an end mark on a last byte at idx would be taken
  function automatic bit end_mark_takes(input logic [31:0] idx, input logic [16:0] space);
    return longint'(idx) < longint'(next_idx) + window_of(space);
  endfunction

  function automatic logic [16:0] pick_space();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 17'($urandom_range(65536, tbsr_pkg::CAPACITY));
    else if (r < 85) return 17'($urandom_range(64, 1));
    else if (r < 90) return SPACE_MAX;
    else if (r < 95) return 17'd0;
    else return 17'($urandom_range(65536, 0));
  endfunction

  task automatic predict_outcome(input logic [1:0] op, input logic [31:0] idx,
                                 input logic [7:0] data, input bit last, input bit eof,
                                 input logic [16:0] space);
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     slot;
    outcome_t        res;
    lo  = next_idx;
    hi  = lo + window_of(space);
    res = '0;
    case (op)
      tbsr_pkg::OP_DATA: begin
        if (idx >= lo && idx < hi) begin
          slot = idx % tbsr_pkg::CAPACITY;
          if (!ring_held[slot]) begin
            ring_held[slot] = 1'b1;
            ring_byte[slot] = data;
            held_cnt++;
          end
        end
        if (last && eof && idx < hi) end_flag = 1'b1;
      end
      tbsr_pkg::OP_MARK: begin
        if (eof) end_flag = 1'b1;
      end
      tbsr_pkg::OP_PULL: begin
        slot = next_idx % tbsr_pkg::CAPACITY;
        if (ring_held[slot] && space != 0) begin
          res.byte_valid  = 1'b1;
          res.out_byte    = ring_byte[slot];
          ring_held[slot] = 1'b0;
          held_cnt--;
          next_idx++;
        end
      end
      default: ;
    endcase
    res.finished = end_flag && (held_cnt == 0);
    res.pending  = held_cnt;
    outcome_q.push_back(res);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] idx, input logic [7:0] data,
                           input bit last, input bit eof, input logic [16:0] space);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, space, eof, data, idx};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_outcome(op, idx, data, last, eof, space);
    items_sent++;
  endtask

  // one segment, bytes in order or reversed; end marks only where they get dropped
  task automatic send_segment(input logic [31:0] start, input int unsigned len,
                              input bit reversed, input logic [16:0] space);
    logic [31:0] idx;
    bit          last;
    bit          eof;
    int unsigned k;
    for (k = 0; k < len; k++) begin
      idx  = reversed ? start + len - 1 - k : start + k;
      last = (idx == start + len - 1);
      eof  = 1'($urandom_range(1));
      if (last && end_mark_takes(idx, space)) eof = 1'b0;
      send_item(tbsr_pkg::OP_DATA, idx, 8'($urandom_range(255)), last, eof, space);
    end
  endtask

  // receiver: random ready, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (outcome_q.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (m_axis_tuser !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata[7:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[8] !== want.finished) begin
          $error("stream_finished: expected %0d, got %0d", want.finished, m_axis_tdata[8]);
          fail_cnt++;
        end
        if (m_axis_tdata[25:9] !== want.pending) begin
          $error("pending_count: expected %0d, got %0d", want.pending, m_axis_tdata[25:9]);
          fail_cnt++;
        end
        results_seen++;
        if (want.byte_valid) bytes_delivered++;
      end
    end
  end

  task automatic test_window_basics();
    src_idle_pct = 16;
    dst_idle_pct = 69;
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);    // pull on empty store
    send_item(OP_UNUSED, '1, 8'hff, 1'b1, 1'b1, SPACE_MAX);              // unused code, all ones
    send_item(tbsr_pkg::OP_MARK, '1, 8'hff, 1'b1, 1'b0, SPACE_MAX);       // marker without end
    send_item(tbsr_pkg::OP_DATA, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);
    send_item(tbsr_pkg::OP_DATA, 32'd0, 8'hab, 1'b0, 1'b0, SPACE_MAX);    // overlap, kept once
    send_item(tbsr_pkg::OP_DATA, 32'd2, 8'hff, 1'b0, 1'b0, 17'd3);        // top of small window
    send_item(tbsr_pkg::OP_DATA, 32'd3, 8'h11, 1'b0, 1'b0, 17'd3);        // just past it
    send_item(tbsr_pkg::OP_DATA, 32'd4096, 8'h22, 1'b0, 1'b0, SPACE_MAX); // capped at capacity
    send_item(tbsr_pkg::OP_DATA, '1, 8'h33, 1'b1, 1'b1, SPACE_MAX);       // far byte, end dropped
    send_item(tbsr_pkg::OP_DATA, 32'd1, 8'h44, 1'b0, 1'b0, 17'd0);        // zero window
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, 17'd0);        // no room downstream
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, 17'd1);
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, 17'd1);        // next byte missing
    send_item(tbsr_pkg::OP_DATA, 32'd1, 8'h5a, 1'b0, 1'b0, 17'd1);
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);
    send_item(tbsr_pkg::OP_DATA, 32'd0, 8'h66, 1'b0, 1'b0, SPACE_MAX);    // already delivered
    send_item(tbsr_pkg::OP_DATA, 32'd4099, 8'h77, 1'b0, 1'b0, SPACE_MAX); // past capacity window
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned src_pct,
                                     input int unsigned dst_pct);
    int unsigned stop_at;
    int unsigned r;
    int unsigned k;
    int unsigned len;
    int          off;
    logic [31:0] idx;
    logic [16:0] sp;
    bit          eof;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    stop_at      = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(8, 1);
        // mostly near the head of the window so pulls make progress
        off = ($urandom_range(99) < 40) ? -int'($urandom_range(3)) : int'($urandom_range(40, 1));
        send_segment(next_idx + off, len, $urandom_range(3) == 0, pick_space());
      end else if (r < 90) begin
        len = $urandom_range(8, 1);
        for (k = 0; k < len; k++)
          send_item(tbsr_pkg::OP_PULL, $urandom(), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), pick_space());
      end else begin
        case ($urandom_range(3))
          0: send_item(OP_UNUSED, $urandom(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 17'($urandom_range(65536, 0)));
          1: send_item(tbsr_pkg::OP_MARK, $urandom(), 8'($urandom_range(255)),
                       1'($urandom_range(1)), 1'b0, 17'($urandom_range(65536, 0)));
          2: begin
            idx = $urandom();
            sp  = pick_space();
            eof = $urandom_range(1) && !end_mark_takes(idx, sp);
            send_item(tbsr_pkg::OP_DATA, idx, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      eof, sp);
          end
          default: send_item(tbsr_pkg::OP_PULL, $urandom(), 8'($urandom_range(255)), 1'b0,
                             1'b0, 17'd0);
        endcase
      end
    end
  endtask

  task automatic test_backpressure();
    logic [31:0] base;
    int unsigned k;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    base         = next_idx;
    stall_left   = 400;
    for (k = 0; k < 48; k++)
      send_item(tbsr_pkg::OP_DATA, base + k, 8'($urandom_range(255)), k == 47, 1'b0,
                SPACE_MAX);
    for (k = 0; k < 48; k++)
      send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);
  endtask

  task automatic test_end_marks();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    // fill every hole and hand out all held bytes
    while (held_cnt != 0) begin
      if (ring_held[next_idx % tbsr_pkg::CAPACITY])
        send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, SPACE_MAX);
      else
        send_item(tbsr_pkg::OP_DATA, next_idx, 8'($urandom_range(255)), 1'b0, 1'b0,
                  SPACE_MAX);
    end
    send_item(tbsr_pkg::OP_DATA, next_idx + 5, 8'h81, 1'b1, 1'b1, 17'd5);  // past window
    send_item(tbsr_pkg::OP_DATA, next_idx - 1, 8'h82, 1'b1, 1'b1, 17'd5);  // below expected
    send_item(tbsr_pkg::OP_MARK, '1, 8'h00, 1'b0, 1'b1, 17'd0);            // empty with end
    send_item(tbsr_pkg::OP_DATA, next_idx + 4095, 8'h83, 1'b0, 1'b0, SPACE_MAX);
    send_item(tbsr_pkg::OP_DATA, next_idx, 8'h84, 1'b1, 1'b1, 17'd1);      // last byte fits
    send_item(tbsr_pkg::OP_PULL, 32'd0, 8'h00, 1'b0, 1'b0, 17'd1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    next_idx      = '0;
    held_cnt      = '0;
    end_flag      = 1'b0;
    src_idle_pct  = 0;
    dst_idle_pct  = 0;
    stall_left    = 0;
    foreach (ring_held[i]) ring_held[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_window_basics();
    test_random_traffic(500, 16, 69);
    test_random_traffic(500, 69, 16);
    test_backpressure();
    test_random_traffic(480, 0, 0);
    test_end_marks();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d items over window, pull, marker and unused codes with idling on both sides",
             items_sent);
    $display("checked %0d result transfers, %0d bytes delivered in order, %0d mismatches",
             results_seen, bytes_delivered, fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
